// ===== rtl/ldqdc_pkg.sv =====
// ldqdc_pkg: shared types, constants and grading / depth functions for the
// latency driven queue depth control block
// no dependencies
package ldqdc_pkg;

   // default parameter values
   localparam int DEF_READ_MAX_DEPTH  = 256;
   localparam int DEF_WRITE_MAX_DEPTH = 128;
   localparam int DEF_OTHER_MAX_DEPTH = 64;
   localparam int DEF_LATENCY_BITS    = 40;

   // target reset values in ns, truncated to the latency width at use
   localparam logic [63:0] READ_TARGET_RESET  = 64'd2000000;
   localparam logic [63:0] WRITE_TARGET_RESET = 64'd10000000;

   // csr port geometry: two 64-bit registers at byte offsets 0 and 8
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_SEL_BIT   = 3;

   // register select codes (value of the address select bit)
   localparam logic REG_READ_TARGET  = 1'b0;
   localparam logic REG_WRITE_TARGET = 1'b1;

   // latency compare width, covers every latency width in range
   localparam int LAT_CALC_BITS = 64;

   // depth arithmetic width, covers max depth 4096 plus two
   localparam int DEPTH_CALC_BITS = 13;

   typedef logic [DEPTH_CALC_BITS-1:0] depth_calc_type;
   typedef logic [LAT_CALC_BITS-1:0]   lat_calc_type;

   // grade codes as seen on the result channel
   typedef logic [2:0] grade_type;
   localparam grade_type GRADE_NONE  = 3'd0;
   localparam grade_type GRADE_GREAT = 3'd1;
   localparam grade_type GRADE_GOOD  = 3'd2;
   localparam grade_type GRADE_BAD   = 3'd3;
   localparam grade_type GRADE_AWFUL = 3'd4;

   function automatic logic grade_pos(grade_type g);
      return (g == GRADE_GREAT) || (g == GRADE_GOOD);
   endfunction

   function automatic logic grade_neg(grade_type g);
      return (g == GRADE_BAD) || (g == GRADE_AWFUL);
   endfunction

   function automatic grade_type grade_of(logic has, lat_calc_type mean,
                                          lat_calc_type target);
      logic [LAT_CALC_BITS:0] twice;
      grade_type              g;
      twice = {target, 1'b0};
      priority if (!has) begin
         g = GRADE_NONE;
      end else if ({1'b0, mean} >= twice) begin
         g = GRADE_AWFUL;
      end else if (mean > target) begin
         g = GRADE_BAD;
      end else if (mean <= (target >> 1)) begin
         g = GRADE_GREAT;
      end else begin
         g = GRADE_GOOD;
      end
      return g;
   endfunction

   // clamp into 1..maxd
   function automatic depth_calc_type clamp_depth(depth_calc_type d, depth_calc_type maxd);
      depth_calc_type r;
      priority if (d == '0) begin
         r = depth_calc_type'(1);
      end else if (d > maxd) begin
         r = maxd;
      end else begin
         r = d;
      end
      return r;
   endfunction

   // d minus max(d >> sh, 1), floored at zero
   function automatic depth_calc_type cut_by(depth_calc_type d, int unsigned sh);
      depth_calc_type c;
      c = d >> sh;
      if (c == '0) begin
         c = depth_calc_type'(1);
      end
      return (c >= d) ? '0 : d - c;
   endfunction

   function automatic depth_calc_type adjust_rw(depth_calc_type d, depth_calc_type maxd,
                                                grade_type self, grade_type other);
      depth_calc_type r;
      r = d;
      if (!((self == GRADE_NONE) || (grade_pos(self) && grade_pos(other)) ||
            (grade_neg(self) && grade_neg(other)))) begin
         if (other == GRADE_NONE) begin
            r = d + depth_calc_type'(1);
         end else begin
            unique case (self)
               GRADE_GOOD:  r = cut_by(d, 3);
               GRADE_GREAT: r = cut_by(d, 2);
               GRADE_BAD:   r = d + depth_calc_type'(1);
               default:     r = d + depth_calc_type'(2);
            endcase
         end
         r = clamp_depth(r, maxd);
      end
      return r;
   endfunction

   function automatic depth_calc_type adjust_other(depth_calc_type d, depth_calc_type maxd,
                                                   grade_type rg, grade_type wg, logic have);
      depth_calc_type r;
      grade_type      g;
      r = d;
      priority if (rg == GRADE_NONE) begin
         g = wg;
      end else if (wg == GRADE_NONE) begin
         g = rg;
      end else begin
         // lower nonzero code is the better grade
         g = (rg < wg) ? rg : wg;
      end
      if ((rg == GRADE_NONE) && (wg == GRADE_NONE)) begin
         r = d + depth_calc_type'(2);
      end else if (have) begin
         unique case (g)
            GRADE_GREAT: r = d + depth_calc_type'(2);
            GRADE_GOOD:  r = d + depth_calc_type'(1);
            GRADE_BAD:   r = cut_by(d, 2);
            default:     r = d >> 1;
         endcase
      end
      return clamp_depth(r, maxd);
   endfunction

endpackage

// ===== rtl/latency_driven_queue_depth_control.sv =====
// latency_driven_queue_depth_control: top level, grades window latencies and
// retunes the read, sync write and other token depths
// depends on ldqdc_pkg
//
// usage
//  - req channel: one item per latency statistics window (read and sync write
//    mean latency with sample flags, other-domain sample flag, stats active)
//  - rsp channel: one item per req item, in order: new read, sync write and
//    other depths, read and write grades, and a rearm flag for the window timer
//  - csr port: apb-style, two 64-bit registers, read target at offset 0 and
//    write target at offset 8; write only while the block is idle
//  - path: an accepted item is held in the input register, then moves into
//    the result register, from which rsp offers it
//  - throughput: one item per cycle unless rsp stalls; the depth update is a
//    single pass of compare and add logic between the input and result registers
//  - a stalled rsp holds its item; the input register keeps taking one more
//    item, then req_stall rises until the result register drains
//  - reset: depths go to their max values, targets to 2 ms and 10 ms,
//    both pipeline stages empty
module latency_driven_queue_depth_control
   import ldqdc_pkg::*;
#(
   parameter int READ_MAX_DEPTH  = DEF_READ_MAX_DEPTH,
   parameter int WRITE_MAX_DEPTH = DEF_WRITE_MAX_DEPTH,
   parameter int OTHER_MAX_DEPTH = DEF_OTHER_MAX_DEPTH,
   parameter int LATENCY_BITS    = DEF_LATENCY_BITS,
   localparam int READ_DW  = $clog2(READ_MAX_DEPTH + 1),
   localparam int WRITE_DW = $clog2(WRITE_MAX_DEPTH + 1),
   localparam int OTHER_DW = $clog2(OTHER_MAX_DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,

   // input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_read_has_samples,
   input  logic [LATENCY_BITS-1:0]  req_read_mean_ns,
   input  logic                     req_write_has_samples,
   input  logic [LATENCY_BITS-1:0]  req_write_mean_ns,
   input  logic                     req_other_has_samples,
   input  logic                     req_stats_active,

   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [READ_DW-1:0]       rsp_read_depth_out,
   output logic [WRITE_DW-1:0]      rsp_write_depth_out,
   output logic [OTHER_DW-1:0]      rsp_other_depth_out,
   output logic [2:0]               rsp_read_grade,
   output logic [2:0]               rsp_write_grade,
   output logic                     rsp_rearm_timer,

   // configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [LATENCY_BITS-1:0] read_target_ff,  read_target_in;
   logic [LATENCY_BITS-1:0] write_target_ff, write_target_in;
   logic                    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      read_target_in  = read_target_ff;
      write_target_in = write_target_ff;
      if (csr_wr) begin
         unique case (csr_paddr[CSR_SEL_BIT])
            REG_READ_TARGET:  read_target_in  = csr_pwdata[LATENCY_BITS-1:0];
            REG_WRITE_TARGET: write_target_in = csr_pwdata[LATENCY_BITS-1:0];
         endcase
      end
   end

   // read mux, only the select bit of the address matters
   always_comb begin
      unique case (csr_paddr[CSR_SEL_BIT])
         REG_READ_TARGET:  csr_prdata = CSR_DATA_BITS'(read_target_ff);
         REG_WRITE_TARGET: csr_prdata = CSR_DATA_BITS'(write_target_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline control: input register (s0) then result register (rsp)
   // ------------------------------------------------------------------
   logic s0_valid_ff, s0_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;     // s0 item may move into the result register
   logic req_accept;
   logic s0_fire;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s0_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign s0_fire    = s0_valid_ff && advance;

   always_comb begin
      priority if (req_accept) begin
         s0_valid_in = 1'b1;
      end else if (advance) begin
         s0_valid_in = 1'b0;
      end else begin
         s0_valid_in = s0_valid_ff;
      end
   end

   always_comb begin
      priority if (s0_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // input register payload
   logic                    s0_read_has_ff,  s0_read_has_in;
   logic [LATENCY_BITS-1:0] s0_read_mean_ff, s0_read_mean_in;
   logic                    s0_write_has_ff,  s0_write_has_in;
   logic [LATENCY_BITS-1:0] s0_write_mean_ff, s0_write_mean_in;
   logic                    s0_other_has_ff, s0_other_has_in;
   logic                    s0_active_ff,    s0_active_in;

   always_comb begin
      s0_read_has_in   = s0_read_has_ff;
      s0_read_mean_in  = s0_read_mean_ff;
      s0_write_has_in  = s0_write_has_ff;
      s0_write_mean_in = s0_write_mean_ff;
      s0_other_has_in  = s0_other_has_ff;
      s0_active_in     = s0_active_ff;
      if (req_accept) begin
         s0_read_has_in   = req_read_has_samples;
         s0_read_mean_in  = req_read_mean_ns;
         s0_write_has_in  = req_write_has_samples;
         s0_write_mean_in = req_write_mean_ns;
         s0_other_has_in  = req_other_has_samples;
         s0_active_in     = req_stats_active;
      end
   end

   // ------------------------------------------------------------------
   // grading and depth update, one combinational pass
   // ------------------------------------------------------------------
   logic [READ_DW-1:0]  read_depth_ff,  read_depth_in;
   logic [WRITE_DW-1:0] write_depth_ff, write_depth_in;
   logic [OTHER_DW-1:0] other_depth_ff, other_depth_in;

   grade_type      read_grade_c, write_grade_c;
   depth_calc_type read_next_c, write_next_c, other_next_c;
   logic           rearm_c;

   assign read_grade_c  = grade_of(s0_read_has_ff, LAT_CALC_BITS'(s0_read_mean_ff),
                                   LAT_CALC_BITS'(read_target_ff));
   assign write_grade_c = grade_of(s0_write_has_ff, LAT_CALC_BITS'(s0_write_mean_ff),
                                   LAT_CALC_BITS'(write_target_ff));

   // each domain looks at its own grade against the other one
   assign read_next_c  = adjust_rw(DEPTH_CALC_BITS'(read_depth_ff),
                                   DEPTH_CALC_BITS'(READ_MAX_DEPTH),
                                   read_grade_c, write_grade_c);
   assign write_next_c = adjust_rw(DEPTH_CALC_BITS'(write_depth_ff),
                                   DEPTH_CALC_BITS'(WRITE_MAX_DEPTH),
                                   write_grade_c, read_grade_c);
   assign other_next_c = adjust_other(DEPTH_CALC_BITS'(other_depth_ff),
                                      DEPTH_CALC_BITS'(OTHER_MAX_DEPTH),
                                      read_grade_c, write_grade_c, s0_other_has_ff);

   // while stats are not active, restart the window when latency is off target or other is throttled
   assign rearm_c = !s0_active_ff &&
                    (grade_neg(read_grade_c) || grade_neg(write_grade_c) ||
                     (other_next_c < DEPTH_CALC_BITS'(OTHER_MAX_DEPTH)));

   always_comb begin
      read_depth_in  = read_depth_ff;
      write_depth_in = write_depth_ff;
      other_depth_in = other_depth_ff;
      if (s0_fire) begin
         read_depth_in  = read_next_c[READ_DW-1:0];
         write_depth_in = write_next_c[WRITE_DW-1:0];
         other_depth_in = other_next_c[OTHER_DW-1:0];
      end
   end

   // result register payload
   logic [READ_DW-1:0]  rsp_read_depth_ff,  rsp_read_depth_in;
   logic [WRITE_DW-1:0] rsp_write_depth_ff, rsp_write_depth_in;
   logic [OTHER_DW-1:0] rsp_other_depth_ff, rsp_other_depth_in;
   grade_type           rsp_read_grade_ff,  rsp_read_grade_in;
   grade_type           rsp_write_grade_ff, rsp_write_grade_in;
   logic                rsp_rearm_ff,       rsp_rearm_in;

   always_comb begin
      rsp_read_depth_in  = rsp_read_depth_ff;
      rsp_write_depth_in = rsp_write_depth_ff;
      rsp_other_depth_in = rsp_other_depth_ff;
      rsp_read_grade_in  = rsp_read_grade_ff;
      rsp_write_grade_in = rsp_write_grade_ff;
      rsp_rearm_in       = rsp_rearm_ff;
      if (s0_fire) begin
         rsp_read_depth_in  = read_next_c[READ_DW-1:0];
         rsp_write_depth_in = write_next_c[WRITE_DW-1:0];
         rsp_other_depth_in = other_next_c[OTHER_DW-1:0];
         rsp_read_grade_in  = read_grade_c;
         rsp_write_grade_in = write_grade_c;
         rsp_rearm_in       = rearm_c;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         read_target_ff  <= LATENCY_BITS'(READ_TARGET_RESET);
         write_target_ff <= LATENCY_BITS'(WRITE_TARGET_RESET);
         s0_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         read_depth_ff   <= READ_DW'(READ_MAX_DEPTH);
         write_depth_ff  <= WRITE_DW'(WRITE_MAX_DEPTH);
         other_depth_ff  <= OTHER_DW'(OTHER_MAX_DEPTH);
      end else begin
         read_target_ff  <= read_target_in;
         write_target_ff <= write_target_in;
         s0_valid_ff     <= s0_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         read_depth_ff   <= read_depth_in;
         write_depth_ff  <= write_depth_in;
         other_depth_ff  <= other_depth_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s0_read_has_ff     <= s0_read_has_in;
      s0_read_mean_ff    <= s0_read_mean_in;
      s0_write_has_ff    <= s0_write_has_in;
      s0_write_mean_ff   <= s0_write_mean_in;
      s0_other_has_ff    <= s0_other_has_in;
      s0_active_ff       <= s0_active_in;
      rsp_read_depth_ff  <= rsp_read_depth_in;
      rsp_write_depth_ff <= rsp_write_depth_in;
      rsp_other_depth_ff <= rsp_other_depth_in;
      rsp_read_grade_ff  <= rsp_read_grade_in;
      rsp_write_grade_ff <= rsp_write_grade_in;
      rsp_rearm_ff       <= rsp_rearm_in;
   end

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_depth_out  = rsp_read_depth_ff;
   assign rsp_write_depth_out = rsp_write_depth_ff;
   assign rsp_other_depth_out = rsp_other_depth_ff;
   assign rsp_read_grade      = rsp_read_grade_ff;
   assign rsp_write_grade     = rsp_write_grade_ff;
   assign rsp_rearm_timer     = rsp_rearm_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // stored depths never leave 1..max
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      (read_depth_ff != '0) && (read_depth_ff <= READ_DW'(READ_MAX_DEPTH)) &&
      (write_depth_ff != '0) && (write_depth_ff <= WRITE_DW'(WRITE_MAX_DEPTH)) &&
      (other_depth_ff != '0) && (other_depth_ff <= OTHER_DW'(OTHER_MAX_DEPTH)))
      else $error("stored depth out of range");

   // an empty input register never pushes back
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("req_stall with empty input register");

   // the shown result and the stored state move together
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      s0_fire |=> (rsp_read_depth_out == read_depth_ff) &&
                  (rsp_write_depth_out == write_depth_ff) &&
                  (rsp_other_depth_out == other_depth_ff) && rsp_valid)
      else $error("result depths differ from stored depths");

endmodule

// ===== tb/sv/tb_latency_driven_queue_depth_control.sv =====
// tb_latency_driven_queue_depth_control: self-checking testbench for the latency
// driven queue depth control block, with its own depth and grade predictor
// depends on ldqdc_pkg and latency_driven_queue_depth_control
`timescale 1ns / 100ps

module tb_latency_driven_queue_depth_control;
   import ldqdc_pkg::*;

   localparam int LB        = DEF_LATENCY_BITS;
   localparam int READ_MAX  = DEF_READ_MAX_DEPTH;
   localparam int WRITE_MAX = DEF_WRITE_MAX_DEPTH;
   localparam int OTHER_MAX = DEF_OTHER_MAX_DEPTH;
   localparam int READ_DW   = $clog2(READ_MAX + 1);
   localparam int WRITE_DW  = $clog2(WRITE_MAX + 1);
   localparam int OTHER_DW  = $clog2(OTHER_MAX + 1);

   localparam logic [63:0] LAT_MAX = (64'd1 << LB) - 64'd1;

   // register byte offsets, select bit above the 8-byte stride
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_READ_TARGET  = {REG_READ_TARGET, 3'b000};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_WRITE_TARGET = {REG_WRITE_TARGET, 3'b000};

   // receiver stall behaviors
   localparam int STALL_NONE    = 0;
   localparam int STALL_RANDOM  = 1;
   localparam int STALL_PATTERN = 2;

   // length of the long receiver hold-off, in cycles
   localparam int HOLD_CYCLES = 60;

   typedef logic [LB-1:0] lat_type;

   // one statistics window as offered on the req channel
   typedef struct {
      logic    rd_has;
      lat_type rd_mean;
      logic    wr_has;
      lat_type wr_mean;
      logic    ot_has;
      logic    active;
   } window_type;

   // one retune decision as shown on the rsp channel
   typedef struct {
      int unsigned rd_depth;
      int unsigned wr_depth;
      int unsigned ot_depth;
      grade_type   rd_grade;
      grade_type   wr_grade;
      logic        rearm;
   } retune_type;

   // ---------------------------------------------------------------------------
   // clock, reset and dut signals; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid             = 1'b0;
   logic                     req_stall;
   logic                     req_read_has_samples  = 1'b0;
   lat_type                  req_read_mean_ns      = '0;
   logic                     req_write_has_samples = 1'b0;
   lat_type                  req_write_mean_ns     = '0;
   logic                     req_other_has_samples = 1'b0;
   logic                     req_stats_active      = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [READ_DW-1:0]       rsp_read_depth_out;
   logic [WRITE_DW-1:0]      rsp_write_depth_out;
   logic [OTHER_DW-1:0]      rsp_other_depth_out;
   logic [2:0]               rsp_read_grade;
   logic [2:0]               rsp_write_grade;
   logic                     rsp_rearm_timer;

   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   latency_driven_queue_depth_control dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_read_has_samples  (req_read_has_samples),
      .req_read_mean_ns      (req_read_mean_ns),
      .req_write_has_samples (req_write_has_samples),
      .req_write_mean_ns     (req_write_mean_ns),
      .req_other_has_samples (req_other_has_samples),
      .req_stats_active      (req_stats_active),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_depth_out    (rsp_read_depth_out),
      .rsp_write_depth_out   (rsp_write_depth_out),
      .rsp_other_depth_out   (rsp_other_depth_out),
      .rsp_read_grade        (rsp_read_grade),
      .rsp_write_grade       (rsp_write_grade),
      .rsp_rearm_timer       (rsp_rearm_timer),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // ---------------------------------------------------------------------------
   // predictor state: targets as last written, depths as after the last item
   // ---------------------------------------------------------------------------
   lat_type     read_tgt  = lat_type'(READ_TARGET_RESET);
   lat_type     write_tgt = lat_type'(WRITE_TARGET_RESET);
   int unsigned rd_depth  = READ_MAX;
   int unsigned wr_depth  = WRITE_MAX;
   int unsigned ot_depth  = OTHER_MAX;

   window_type window_q[$];         // windows waiting to be offered
   retune_type depth_expect_q[$];   // predicted results, oldest first

   int unsigned queued_count  = 0;
   int unsigned checked_count = 0;
   int unsigned error_count   = 0;

   // knobs set by the stimulus sequence
   int   stall_mode  = STALL_NONE;
   logic send_calm   = 1'b1;
   int   hold_ticket = 0;

   function automatic logic grade_is_pos(grade_type g);
      return (g == GRADE_GREAT) || (g == GRADE_GOOD);
   endfunction

   function automatic logic grade_is_neg(grade_type g);
      return (g == GRADE_BAD) || (g == GRADE_AWFUL);
   endfunction

   // grade a window mean against its target; doubling needs one extra bit
   function automatic grade_type grade_window(logic has, lat_type mean, lat_type tgt);
      logic [63:0] m;
      logic [63:0] t;
      m = mean;
      t = tgt;
      if (!has) return GRADE_NONE;
      if (m >= 2 * t) return GRADE_AWFUL;
      if (m > t) return GRADE_BAD;
      if (m <= t / 2) return GRADE_GREAT;
      return GRADE_GOOD;
   endfunction

   function automatic int unsigned clamp_to(int n, int unsigned maxd);
      if (n < 1) return 1;
      if (n > int'(maxd)) return maxd;
      return n;
   endfunction

   // d less max(d/div, 1)
   function automatic int shave(int unsigned d, int unsigned div);
      int unsigned c;
      c = d / div;
      if (c < 1) c = 1;
      return int'(d) - int'(c);
   endfunction

   // read or sync write depth from its own grade and the opposite one
   function automatic int unsigned retune_rw(int unsigned d, int unsigned maxd,
                                             grade_type self, grade_type opp);
      int n;
      if (self == GRADE_NONE || (grade_is_pos(self) && grade_is_pos(opp)) ||
          (grade_is_neg(self) && grade_is_neg(opp))) return d;
      if (opp == GRADE_NONE) begin
         n = d + 1;
      end else begin
         case (self)
            GRADE_GOOD:  n = shave(d, 8);
            GRADE_GREAT: n = shave(d, 4);
            GRADE_BAD:   n = d + 1;
            default:     n = d + 2;
         endcase
      end
      return clamp_to(n, maxd);
   endfunction

   function automatic int unsigned retune_other(int unsigned d, grade_type rg,
                                                grade_type wg, logic have);
      int        n;
      grade_type g;
      n = d;
      if (rg == GRADE_NONE && wg == GRADE_NONE) begin
         n = d + 2;
      end else if (have) begin
         // lower code is the better grade
         if (rg == GRADE_NONE)      g = wg;
         else if (wg == GRADE_NONE) g = rg;
         else                       g = (rg < wg) ? rg : wg;
         case (g)
            GRADE_GREAT: n = d + 2;
            GRADE_GOOD:  n = d + 1;
            GRADE_BAD:   n = shave(d, 4);
            default:     n = d / 2;
         endcase
      end
      return clamp_to(n, OTHER_MAX);
   endfunction

   // advance the predicted depths by one window and give the expected result
   function automatic retune_type predict_window(window_type w);
      retune_type r;
      r.rd_grade = grade_window(w.rd_has, w.rd_mean, read_tgt);
      r.wr_grade = grade_window(w.wr_has, w.wr_mean, write_tgt);
      rd_depth   = retune_rw(rd_depth, READ_MAX, r.rd_grade, r.wr_grade);
      wr_depth   = retune_rw(wr_depth, WRITE_MAX, r.wr_grade, r.rd_grade);
      ot_depth   = retune_other(ot_depth, r.rd_grade, r.wr_grade, w.ot_has);
      r.rd_depth = rd_depth;
      r.wr_depth = wr_depth;
      r.ot_depth = ot_depth;
      r.rearm    = !w.active && (grade_is_neg(r.rd_grade) || grade_is_neg(r.wr_grade) ||
                                 ot_depth < OTHER_MAX);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // driver: offers queued windows in bursts, holds the item while stalled
   // ---------------------------------------------------------------------------
   window_type on_wire;
   int         burst_left = 0;
   int         gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // accepted at this edge: predict before anything new goes out
         if (req_valid && !req_stall) begin
            depth_expect_q.push_back(predict_window(on_wire));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (window_q.size() > 0) begin
               on_wire = window_q.pop_front();
               req_read_has_samples  <= on_wire.rd_has;
               req_read_mean_ns      <= on_wire.rd_mean;
               req_write_has_samples <= on_wire.wr_has;
               req_write_mean_ns     <= on_wire.wr_mean;
               req_other_has_samples <= on_wire.ot_has;
               req_stats_active      <= on_wire.active;
               req_valid             <= 1'b1;
               // a new burst starts here; unless send_calm, a gap follows its last item
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0 && !send_calm) gap_left = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver stall: random, a rotating pattern, or a long hold-off on request
   // ---------------------------------------------------------------------------
   logic [15:0] stall_pattern = 16'b1011_0001_1100_0110;
   int          hold_served   = 0;
   int          hold_left     = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM: begin
               rsp_stall <= ($urandom_range(0, 99) < 35);
            end
            STALL_PATTERN: begin
               stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
               rsp_stall     <= stall_pattern[0];
            end
            default: begin
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every accepted result against the oldest prediction
   // ---------------------------------------------------------------------------
   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      retune_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (depth_expect_q.size() == 0) begin
            $display({"%0t: result item with nothing expected, ",
                      "expected none actual depths %0d %0d %0d"},
                     $time, rsp_read_depth_out, rsp_write_depth_out, rsp_other_depth_out);
            error_count++;
         end else begin
            exp_r = depth_expect_q.pop_front();
            check_field("read depth", exp_r.rd_depth, rsp_read_depth_out);
            check_field("write depth", exp_r.wr_depth, rsp_write_depth_out);
            check_field("other depth", exp_r.ot_depth, rsp_other_depth_out);
            check_field("read grade", exp_r.rd_grade, rsp_read_grade);
            check_field("write grade", exp_r.wr_grade, rsp_write_grade);
            check_field("rearm", exp_r.rearm, rsp_rearm_timer);
            checked_count++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic lat_type rand_lat();
      logic [63:0] v;
      v = rand64() & LAT_MAX;
      return lat_type'(v);
   endfunction

   function automatic window_type mk_window(logic rh, lat_type rm, logic wh, lat_type wm,
                                            logic oh, logic act);
      window_type w;
      w.rd_has  = rh;
      w.rd_mean = rm;
      w.wr_has  = wh;
      w.wr_mean = wm;
      w.ot_has  = oh;
      w.active  = act;
      return w;
   endfunction

   // a mean that lands in the wanted grade band, often on a band edge;
   // an empty band (tiny or huge target) falls back to any value
   function automatic lat_type mean_for(grade_type g, lat_type tgt);
      logic [63:0] t;
      logic [63:0] lo;
      logic [63:0] hi;
      t = tgt;
      case (g)
         GRADE_GREAT: begin lo = 0;            hi = t >> 1; end
         GRADE_GOOD:  begin lo = (t >> 1) + 1; hi = t;      end
         GRADE_BAD:   begin
            lo = t + 1;
            hi = (t != 0 && 2 * t - 1 < LAT_MAX) ? 2 * t - 1 : LAT_MAX;
         end
         default:     begin lo = 2 * t;        hi = LAT_MAX; end
      endcase
      if (lo > hi) return rand_lat();
      case ($urandom_range(0, 7))
         0:       return lat_type'(lo);
         1:       return lat_type'(hi);
         default: return lat_type'(lo + rand64() % (hi - lo + 1));
      endcase
   endfunction

   function automatic grade_type pick_grade();
      case ($urandom_range(0, 4))
         0:       return GRADE_NONE;
         1:       return GRADE_GREAT;
         2:       return GRADE_GOOD;
         3:       return GRADE_BAD;
         default: return GRADE_AWFUL;
      endcase
   endfunction

   task automatic queue_window(window_type w);
      window_q.push_back(w);
      queued_count++;
   endtask

   // runs of windows that hold the same grade pair, so depths walk all the
   // way to their limits; about one in five windows is plain noise
   task automatic queue_random(int n);
      int        run;
      grade_type rpick;
      grade_type wpick;
      logic      ohas_bias;
      logic      act;
      while (n > 0) begin
         run       = $urandom_range(4, 24);
         rpick     = pick_grade();
         wpick     = pick_grade();
         ohas_bias = $urandom_range(0, 3) != 0;
         act       = $urandom_range(0, 1);
         for (int i = 0; i < run && n > 0; i++) begin
            if ($urandom_range(0, 9) < 2) begin
               queue_window(mk_window($urandom_range(0, 1), rand_lat(), $urandom_range(0, 1),
                                      rand_lat(), $urandom_range(0, 1), $urandom_range(0, 1)));
            end else begin
               queue_window(mk_window(rpick != GRADE_NONE,
                                      (rpick == GRADE_NONE) ? rand_lat()
                                                            : mean_for(rpick, read_tgt),
                                      wpick != GRADE_NONE,
                                      (wpick == GRADE_NONE) ? rand_lat()
                                                            : mean_for(wpick, write_tgt),
                                      ohas_bias ? ($urandom_range(0, 9) != 0)
                                                : ($urandom_range(0, 9) == 0),
                                      act));
            end
            n--;
         end
      end
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // only called while the block is drained; upper data bits are dropped
   task automatic set_targets(logic [63:0] rd, logic [63:0] wr);
      csr_write(ADDR_READ_TARGET, rd);
      csr_write(ADDR_WRITE_TARGET, wr);
      read_tgt  = lat_type'(rd);
      write_tgt = lat_type'(wr);
   endtask

   // sender pause: wait for every result, then let the pipeline settle
   task automatic wait_drained();
      while (checked_count != queued_count) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      lat_type tr;
      lat_type tw;
      lat_type mx;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed windows against the reset targets, no idling at all
      tr = read_tgt;
      tw = write_tgt;
      mx = lat_type'(LAT_MAX);
      stall_mode = STALL_NONE;
      send_calm  = 1'b1;
      queue_window(mk_window(0, '0, 0, '0, 0, 1));            // nothing sampled
      queue_window(mk_window(1, '0, 0, '0, 1, 1));            // read alone, great
      queue_window(mk_window(1, tr, 1, 2 * tw, 1, 0));        // good edge, awful edge
      queue_window(mk_window(1, tr / 2, 1, tw + 1, 1, 0));    // great edge, bad edge
      queue_window(mk_window(1, tr / 2 + 1, 1, 2 * tw - 1, 0, 0));
      queue_window(mk_window(1, 2 * tr, 1, '0, 1, 0));        // awful, great
      queue_window(mk_window(1, tr + 1, 1, tw, 1, 0));        // bad, good
      queue_window(mk_window(1, mx, 1, mx, 1, 0));            // both awful, other halves
      queue_window(mk_window(1, mx, 0, mx, 1, 0));            // read alone, awful
      queue_window(mk_window(0, mx, 1, tw + 1, 1, 1));        // write alone, bad
      queue_window(mk_window(1, 2 * tr - 1, 1, tw / 2, 1, 0));
      queue_window(mk_window(0, '0, 0, '0, 1, 0));            // no grades, other grows
      // keep cutting the read depth toward its floor
      for (int i = 0; i < 12; i++) begin
         queue_window(mk_window(1, '0, 1, mx, i[0], i[1]));
      end
      wait_drained();

      stall_mode = STALL_RANDOM;
      send_calm  = 1'b0;
      queue_random(40);
      wait_drained();

      // zero targets: every sampled mean grades awful
      set_targets(64'd0, 64'd0);
      stall_mode = STALL_PATTERN;
      queue_random(70);
      wait_drained();

      // all ones; bits above the latency width must be dropped
      set_targets('1, '1);
      stall_mode = STALL_RANDOM;
      send_calm  = 1'b1;
      queue_random(70);
      wait_drained();

      // tiny targets, several grade bands empty or one value wide
      set_targets(64'd1, 64'd3);
      stall_mode = STALL_NONE;
      send_calm  = 1'b0;
      queue_random(70);
      wait_drained();

      set_targets(64'($urandom_range(1000, 1 << 20)), rand64());
      stall_mode = STALL_PATTERN;
      queue_random(70);
      wait_drained();

      // back to the reset targets; a long receiver hold-off while the
      // sender keeps offering, so the block fills and stalls its input
      set_targets(READ_TARGET_RESET, WRITE_TARGET_RESET);
      stall_mode = STALL_RANDOM;
      send_calm  = 1'b1;
      queue_random(80);
      while (checked_count + 70 > queued_count) @(posedge clock);
      hold_ticket++;
      wait_drained();

      // drained; a few more cycles to catch any stray result item
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_latency_driven_queue_depth_control passed");
      end else begin
         $display("tb_latency_driven_queue_depth_control failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("tb_latency_driven_queue_depth_control failed");
      $finish;
   end

endmodule
